// File: rtl/rcp_pkg.sv
`default_nettype none
package rcp_pkg;

  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_NUM   = 3'd1;
  localparam logic [2:0] KIND_SEND  = 3'd2;
  localparam logic [2:0] KIND_EMPTY = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;

  localparam logic [19:0] COUNT_CAP = 20'hFFFFF;
  localparam logic [12:0] LIM_CAP = 13'd4096;

  // One classified byte passed from the front to the back.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       message_start;
  } rcp_item_t;

  typedef struct packed {
    logic [2:0]         out_kind;
    logic [7:0]         data_byte;
    logic signed [63:0] number_value;
    logic [11:0]        arg_length;
    logic [5:0]         arg_index;
    logic               last_arg;
  } rcp_result_t;

endpackage
`default_nettype wire

// File: rtl/rcp_if.sv
`default_nettype none
interface rcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       message_start;
  modport source (output valid, in_byte, message_start, input ready);
  modport sink (input valid, in_byte, message_start, output ready);
endinterface

interface rcp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_kind;
  logic [7:0]         data_byte;
  logic signed [63:0] number_value;
  logic [11:0]        arg_length;
  logic [5:0]         arg_index;
  logic               last_arg;
  modport source (output valid, out_kind, data_byte, number_value, arg_length,
                  arg_index, last_arg, input ready);
  modport sink (input valid, out_kind, data_byte, number_value, arg_length,
                arg_index, last_arg, output ready);
endinterface

interface rcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/rcp_queue.sv
`default_nettype none
// Two-entry queue between the front and the back.
module rcp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rcp_pkg::rcp_item_t push_item,
  output logic                   full,
  input  wire logic              pop,
  output rcp_pkg::rcp_item_t     head,
  output logic                   not_empty
);
  rcp_pkg::rcp_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
endmodule
`default_nettype wire

// File: rtl/rcp_engine.sv
`default_nettype none
// Parser state machine: one byte per cycle while no held result stalls it, one registered result.
module rcp_engine #(
  parameter int MAX_ARGS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [12:0]        max_token_bytes,
  input  wire logic               item_valid,
  input  wire rcp_pkg::rcp_item_t item,
  output logic                    item_take,
  output logic                    res_valid,
  output rcp_pkg::rcp_result_t    res,
  input  wire logic               res_ready
);
  localparam int AW = $clog2(MAX_ARGS + 2);

  typedef enum logic [3:0] {
    HDR_TYPE, HDR_COUNT, ARG_TYPE, NUM_LEAD, NUM_DIG, NUM_STOP, BULK_LEN,
    BULK_SKIP, BULK_DATA, SIMPLE, SKIP, DONE, ERR
  } phase_t;

  phase_t      phase;
  logic [AW-1:0] args_remaining;
  logic [63:0] accumulator;
  logic        negative;
  logic [11:0] token_count;
  logic [11:0] bulk_remaining;
  logic [5:0]  current_index;

  phase_t      phase_next;
  logic [AW-1:0] args_next;
  logic [63:0] acc_next;
  logic        neg_next;
  logic [11:0] tok_next;
  logic [11:0] bulk_next;
  logic [5:0]  idx_next;
  logic        emit;
  rcp_pkg::rcp_result_t r_next;

  // Working copies after an optional message_start clear.
  phase_t      ph;
  logic [AW-1:0] ar;
  logic [63:0] acc;
  logic        ng;
  logic [11:0] tc;
  logic [11:0] br;
  logic [5:0]  ci;
  logic [7:0]  b;
  logic [12:0] lim;
  logic        push_ok;
  logic        is_dig;
  logic [3:0]  dig;
  logic [63:0] cnt_mul;
  logic [63:0] mag_mul;
  logic [63:0] mag_lim;

  assign item_take = item_valid && (!res_valid || res_ready);

  always_comb begin
    b   = item.in_byte;
    lim = (max_token_bytes > rcp_pkg::LIM_CAP) ? rcp_pkg::LIM_CAP : max_token_bytes;
    if (item.message_start) begin
      ph = HDR_TYPE; ar = '0; acc = '0; ng = 1'b0; tc = '0; br = '0; ci = '0;
    end else begin
      ph = phase; ar = args_remaining; acc = accumulator; ng = negative;
      tc = token_count; br = bulk_remaining; ci = current_index;
    end
    push_ok = ({1'b0, tc} + 13'd1) < lim;
    is_dig  = (b >= rcp_pkg::CH_ZERO) && (b <= rcp_pkg::CH_NINE);
    dig     = 4'(b - rcp_pkg::CH_ZERO);
    cnt_mul = (acc * 64'd10) + 64'(dig);
    mag_mul = cnt_mul;
    // Largest magnitude that can take this digit without passing 2^63.
    mag_lim = (dig == 4'd9) ? 64'd922337203685477579 : 64'd922337203685477580;

    phase_next = ph; args_next = ar; acc_next = acc; neg_next = ng;
    tok_next = tc; bulk_next = br; idx_next = ci;
    emit = 1'b0;
    r_next = '0;

    case (ph)
      HDR_TYPE: begin
        if (b == rcp_pkg::CH_CR || !push_ok || b != rcp_pkg::CH_STAR) begin
          phase_next = ERR; emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_ERR;
        end else begin
          tok_next = tc + 12'd1; phase_next = HDR_COUNT;
        end
      end
      HDR_COUNT, BULK_LEN: begin
        if (b == rcp_pkg::CH_CR) begin
          if (ph == HDR_COUNT) begin
            if (acc > 64'(MAX_ARGS)) begin
              phase_next = ERR; emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_ERR;
            end else begin
              args_next = AW'(acc); idx_next = '0; phase_next = SKIP;
              if (acc == 64'd0) begin
                emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_EMPTY;
                r_next.last_arg = 1'b1;
              end
            end
          end else if (acc >= 64'(lim)) begin
            phase_next = ERR; emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_ERR;
          end else begin
            bulk_next = acc[11:0]; phase_next = BULK_SKIP;
          end
        end else if (!push_ok || !is_dig) begin
          phase_next = ERR; emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_ERR;
        end else begin
          tok_next = tc + 12'd1;
          acc_next = (cnt_mul > 64'(rcp_pkg::COUNT_CAP)) ? 64'(rcp_pkg::COUNT_CAP) : cnt_mul;
        end
      end
      ARG_TYPE: begin
        if (b == rcp_pkg::CH_CR || !push_ok) begin
          phase_next = ERR; emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_ERR;
        end else begin
          tok_next = tc + 12'd1;
          case (b)
            rcp_pkg::CH_COLON:  phase_next = NUM_LEAD;
            rcp_pkg::CH_DOLLAR: phase_next = BULK_LEN;
            rcp_pkg::CH_PLUS:   phase_next = SIMPLE;
            default: begin
              phase_next = ERR; emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_ERR;
            end
          endcase
        end
      end
      NUM_LEAD, NUM_DIG, NUM_STOP: begin
        if (b == rcp_pkg::CH_CR) begin
          emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_NUM;
          if (ng) begin
            r_next.number_value = -$signed(acc);
          end else begin
            r_next.number_value = acc[63] ? 64'sh7FFFFFFFFFFFFFFF : $signed(acc);
          end
          r_next.arg_index = ci;
          r_next.last_arg  = (ar == AW'(1));
          idx_next = ci + 6'd1;
          if (ar != '0) begin
            args_next = ar - AW'(1);
          end
          phase_next = SKIP;
        end else if (!push_ok) begin
          phase_next = ERR; emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_ERR;
        end else begin
          tok_next = tc + 12'd1;
          if (ph == NUM_LEAD) begin
            if (b == rcp_pkg::CH_SPACE || (b >= rcp_pkg::CH_TAB && b <= rcp_pkg::CH_FF)) begin
              phase_next = NUM_LEAD;
            end else if (b == rcp_pkg::CH_PLUS || b == rcp_pkg::CH_MINUS) begin
              neg_next = (b == rcp_pkg::CH_MINUS); phase_next = NUM_DIG;
            end else if (is_dig) begin
              acc_next = (acc > mag_lim) ? 64'h8000000000000000 : mag_mul;
              phase_next = NUM_DIG;
            end else begin
              phase_next = NUM_STOP;
            end
          end else if (ph == NUM_DIG) begin
            if (is_dig) begin
              acc_next = (acc > mag_lim) ? 64'h8000000000000000 : mag_mul;
            end else begin
              phase_next = NUM_STOP;
            end
          end
        end
      end
      BULK_SKIP: phase_next = BULK_DATA;
      BULK_DATA: begin
        emit = 1'b1;
        if (br != '0) begin
          bulk_next = br - 12'd1;
          r_next.out_kind = rcp_pkg::KIND_DATA; r_next.data_byte = b;
          r_next.arg_index = ci;
        end else begin
          r_next.out_kind = rcp_pkg::KIND_SEND; r_next.arg_length = acc[11:0];
          r_next.arg_index = ci; r_next.last_arg = (ar == AW'(1));
          idx_next = ci + 6'd1;
          if (ar != '0) begin
            args_next = ar - AW'(1);
          end
          phase_next = SKIP;
        end
      end
      SIMPLE: begin
        emit = 1'b1;
        if (b == rcp_pkg::CH_CR) begin
          r_next.out_kind = rcp_pkg::KIND_SEND;
          r_next.arg_length = (tc != '0) ? tc - 12'd1 : 12'd0;
          r_next.arg_index = ci; r_next.last_arg = (ar == AW'(1));
          idx_next = ci + 6'd1;
          if (ar != '0) begin
            args_next = ar - AW'(1);
          end
          phase_next = SKIP;
        end else if (!push_ok) begin
          phase_next = ERR; r_next.out_kind = rcp_pkg::KIND_ERR;
        end else begin
          tok_next = tc + 12'd1;
          r_next.out_kind = rcp_pkg::KIND_DATA; r_next.data_byte = b;
          r_next.arg_index = ci;
        end
      end
      SKIP: begin
        phase_next = (ar != '0) ? ARG_TYPE : DONE;
        tok_next = '0; acc_next = '0; neg_next = 1'b0;
      end
      ERR: begin
        emit = 1'b1; r_next.out_kind = rcp_pkg::KIND_ERR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= HDR_TYPE; args_remaining <= '0; accumulator <= '0;
      negative <= 1'b0; token_count <= '0; bulk_remaining <= '0;
      current_index <= '0; res_valid <= 1'b0;
    end else begin
      if (item_take) begin
        phase <= phase_next; args_remaining <= args_next;
        accumulator <= acc_next; negative <= neg_next;
        token_count <= tok_next; bulk_remaining <= bulk_next;
        current_index <= idx_next;
        res_valid <= emit;
        res <= r_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result lost while stalled");
  assert property (@(posedge clk) disable iff (rst)
    phase == ERR && item_take && !item.message_start
    |=> res_valid && res.out_kind == rcp_pkg::KIND_ERR)
    else $error("error not held");
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.out_kind == rcp_pkg::KIND_EMPTY |-> res.last_arg)
    else $error("empty command without last flag");
endmodule
`default_nettype wire

// File: rtl/resp_command_parser_unit.sv
`default_nettype none
// RESP command parser. Bytes of a command stream enter on in_ch at one item
// per clock while the queue has room and pass through a two-entry queue into
// the parser engine, which consumes one item per cycle while its result is
// not held and returns at most one result item per byte in a registered
// output stage. A byte is registered in the queue, and its result in the
// engine's output stage. A stalled output holds the engine, and the input
// stalls once the queue is full. The token limit must be written on cfg_ch
// only while the block is idle; the block itself does not enforce this, and
// cfg_ch is always ready.
module resp_command_parser_unit #(
  parameter int MAX_ARGS = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  rcp_in_if.sink     in_ch,
  rcp_out_if.source  out_ch,
  rcp_cfg_if.sink    cfg_ch
);
  logic [12:0] max_token_bytes;
  rcp_pkg::rcp_item_t in_item;
  rcp_pkg::rcp_item_t head;
  rcp_pkg::rcp_result_t res;
  logic q_full;
  logic q_ne;
  logic take;
  logic res_valid;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_token_bytes <= 13'd256;
    end else if (cfg_ch.valid) begin
      max_token_bytes <= cfg_ch.data;
    end
  end

  // The front accepts whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign in_item.in_byte = in_ch.in_byte;
  assign in_item.message_start = in_ch.message_start;

  rcp_queue u_queue (
    .clk(clk), .rst(rst),
    .push(in_ch.valid && !q_full), .push_item(in_item), .full(q_full),
    .pop(take), .head(head), .not_empty(q_ne)
  );

  rcp_engine #(.MAX_ARGS(MAX_ARGS)) u_engine (
    .clk(clk), .rst(rst), .max_token_bytes(max_token_bytes),
    .item_valid(q_ne), .item(head), .item_take(take),
    .res_valid(res_valid), .res(res), .res_ready(out_ch.ready)
  );

  assign out_ch.valid        = res_valid;
  assign out_ch.out_kind     = res.out_kind;
  assign out_ch.data_byte    = res.data_byte;
  assign out_ch.number_value = res.number_value;
  assign out_ch.arg_length   = res.arg_length;
  assign out_ch.arg_index    = res.arg_index;
  assign out_ch.last_arg     = res.last_arg;
endmodule
`default_nettype wire

// File: sim/resp_command_parser_unit_tb.sv
`default_nettype none
module resp_command_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Parser phases of the predictor, following the engine's own sequence.
  typedef enum logic [3:0] {
    PH_HDR_TYPE, PH_HDR_COUNT, PH_ARG_TYPE, PH_NUM_LEAD, PH_NUM_DIG,
    PH_NUM_STOP, PH_BULK_LEN, PH_BULK_SKIP, PH_BULK_DATA, PH_SIMPLE,
    PH_SKIP, PH_DONE, PH_ERROR
  } parse_phase_t;

  localparam int          ARG_LIMIT = 64;
  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

  // One byte of the command stream together with its message_start flag.
  typedef struct {
    logic [7:0] b;
    logic       st;
  } stream_byte_t;

  // The scoreboard carries its own copy of the parser state and the token
  // limit. Every accepted byte is run through the predictor, and any result
  // it would cause is queued; results from the block are checked in order.
  class parse_scoreboard;
    logic [12:0]          token_limit;
    parse_phase_t         phase;
    int                   args_left;
    logic [63:0]          acc;
    bit                   neg;
    int                   tok_cnt;
    int                   bulk_left;
    int                   cur_idx;
    rcp_pkg::rcp_result_t expected_q[$];
    int                   failures;
    int                   shown;

    function new();
      token_limit = 13'd256;
      failures = 0;
      shown = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = PH_HDR_TYPE;
      args_left = 0;
      acc = '0;
      neg = 1'b0;
      tok_cnt = 0;
      bulk_left = 0;
      cur_idx = 0;
    endfunction

    function void emit(logic [2:0] kind, logic [7:0] data, logic [63:0] num,
                       int len, int idx, bit last);
      rcp_pkg::rcp_result_t r;
      r.out_kind = kind;
      r.data_byte = data;
      r.number_value = num;
      r.arg_length = len[11:0];
      r.arg_index = idx[5:0];
      r.last_arg = last;
      expected_q.push_back(r);
    endfunction

    function void fail_parse();
      phase = PH_ERROR;
      emit(rcp_pkg::KIND_ERR, '0, '0, 0, 0, 1'b0);
    endfunction

    function bit push_token(int lim);
      if (tok_cnt + 1 >= lim) return 1'b0;
      tok_cnt++;
      return 1'b1;
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= rcp_pkg::CH_ZERO && b <= rcp_pkg::CH_NINE;
    endfunction

    function void arg_end(logic [2:0] kind, logic [63:0] num, int len);
      emit(kind, '0, num, len, cur_idx, args_left == 1);
      cur_idx++;
      if (args_left > 0) args_left--;
      phase = PH_SKIP;
    endfunction

    function void add_count_digit(logic [7:0] b);
      acc = acc * 64'd10 + 64'(b - rcp_pkg::CH_ZERO);
      if (acc > 64'(rcp_pkg::COUNT_CAP)) acc = 64'(rcp_pkg::COUNT_CAP);
    endfunction

    function void add_mag_digit(logic [7:0] b);
      logic [63:0] d;
      d = 64'(b - rcp_pkg::CH_ZERO);
      if (acc > (MAG_LIMIT - d) / 64'd10) acc = MAG_LIMIT;
      else acc = acc * 64'd10 + d;
    endfunction

    // Predicts the result, if any, of one accepted byte.
    function void note_byte(logic [7:0] b, logic st);
      int lim;
      logic [63:0] v;
      lim = (token_limit > rcp_pkg::LIM_CAP) ? 4096 : int'(token_limit);
      if (st) clear_state();
      case (phase)
        PH_HDR_TYPE: begin
          if (b == rcp_pkg::CH_CR || !push_token(lim) || b != rcp_pkg::CH_STAR) fail_parse();
          else phase = PH_HDR_COUNT;
        end
        PH_HDR_COUNT: begin
          if (b == rcp_pkg::CH_CR) begin
            if (acc > 64'(ARG_LIMIT)) begin
              fail_parse();
            end else begin
              args_left = int'(acc);
              cur_idx = 0;
              phase = PH_SKIP;
              if (args_left == 0) emit(rcp_pkg::KIND_EMPTY, '0, '0, 0, 0, 1'b1);
            end
          end else if (!push_token(lim) || !is_digit(b)) begin
            fail_parse();
          end else begin
            add_count_digit(b);
          end
        end
        PH_ARG_TYPE: begin
          if (b == rcp_pkg::CH_CR || !push_token(lim)) fail_parse();
          else if (b == rcp_pkg::CH_COLON) phase = PH_NUM_LEAD;
          else if (b == rcp_pkg::CH_DOLLAR) phase = PH_BULK_LEN;
          else if (b == rcp_pkg::CH_PLUS) phase = PH_SIMPLE;
          else fail_parse();
        end
        PH_NUM_LEAD, PH_NUM_DIG, PH_NUM_STOP: begin
          if (b == rcp_pkg::CH_CR) begin
            if (neg) v = 64'd0 - acc;
            else v = (acc > MAG_LIMIT - 64'd1) ? MAG_LIMIT - 64'd1 : acc;
            arg_end(rcp_pkg::KIND_NUM, v, 0);
          end else if (!push_token(lim)) begin
            fail_parse();
          end else if (phase == PH_NUM_LEAD) begin
            // Leading blanks are skipped; a sign or digit starts the value.
            if (b == rcp_pkg::CH_SPACE || (b >= rcp_pkg::CH_TAB && b <= rcp_pkg::CH_FF)) begin
            end else if (b == rcp_pkg::CH_PLUS || b == rcp_pkg::CH_MINUS) begin
              neg = (b == rcp_pkg::CH_MINUS);
              phase = PH_NUM_DIG;
            end else if (is_digit(b)) begin
              add_mag_digit(b);
              phase = PH_NUM_DIG;
            end else begin
              phase = PH_NUM_STOP;
            end
          end else if (phase == PH_NUM_DIG) begin
            if (is_digit(b)) add_mag_digit(b);
            else phase = PH_NUM_STOP;
          end
        end
        PH_BULK_LEN: begin
          if (b == rcp_pkg::CH_CR) begin
            if (acc >= 64'(lim)) begin
              fail_parse();
            end else begin
              bulk_left = int'(acc);
              phase = PH_BULK_SKIP;
            end
          end else if (!push_token(lim) || !is_digit(b)) begin
            fail_parse();
          end else begin
            add_count_digit(b);
          end
        end
        PH_BULK_SKIP: phase = PH_BULK_DATA;
        PH_BULK_DATA: begin
          if (bulk_left > 0) begin
            bulk_left--;
            emit(rcp_pkg::KIND_DATA, b, '0, 0, cur_idx, 1'b0);
          end else begin
            arg_end(rcp_pkg::KIND_SEND, '0, int'(acc[11:0]));
          end
        end
        PH_SIMPLE: begin
          if (b == rcp_pkg::CH_CR)
            arg_end(rcp_pkg::KIND_SEND, '0, (tok_cnt > 0) ? tok_cnt - 1 : 0);
          else if (!push_token(lim)) fail_parse();
          else emit(rcp_pkg::KIND_DATA, b, '0, 0, cur_idx, 1'b0);
        end
        PH_SKIP: begin
          phase = (args_left > 0) ? PH_ARG_TYPE : PH_DONE;
          tok_cnt = 0;
          acc = '0;
          neg = 1'b0;
        end
        PH_ERROR: emit(rcp_pkg::KIND_ERR, '0, '0, 0, 0, 1'b0);
        default: ;
      endcase
    endfunction

    function void check_result(rcp_pkg::rcp_result_t got);
      rcp_pkg::rcp_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result item: kind %0d data %02h num %0d len %0d idx %0d last %0b",
                   got.out_kind, got.data_byte, got.number_value, got.arg_length,
                   got.arg_index, got.last_arg);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("result mismatch: expected kind %0d data %02h num %0d len %0d idx %0d last %0b",
                   want.out_kind, want.data_byte, want.number_value, want.arg_length,
                   want.arg_index, want.last_arg);
          $display("                 actual   kind %0d data %02h num %0d len %0d idx %0d last %0b",
                   got.out_kind, got.data_byte, got.number_value, got.arg_length,
                   got.arg_index, got.last_arg);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rcp_in_if  in_ch();
  rcp_out_if out_ch();
  rcp_cfg_if cfg_ch();

  resp_command_parser_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  parse_scoreboard sb = new();
  stream_byte_t    stream_q[$];
  // When quiet is set, neither side adds random gaps or stalls, so the block runs at full rate.
  bit              quiet;
  int              bytes_sent;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // A gap or stall length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic st);
    stream_byte_t s;
    s.b = b;
    s.st = st;
    stream_q.push_back(s);
  endfunction

  // Appends the text of a string; the first byte opens a new command if asked.
  function automatic void add_text(string s, bit opens);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], opens && i == 0);
  endfunction

  function automatic void add_decimal(int unsigned n);
    add_text($sformatf("%0d", n), 1'b0);
  endfunction

  function automatic int effective_limit();
    return (sb.token_limit > rcp_pkg::LIM_CAP) ? 4096 : int'(sb.token_limit);
  endfunction

  // Builds one command with random content, mostly well-formed, then sometimes
  // corrupts it: a byte overwritten, the tail cut off, or stray bytes added.
  function automatic void gen_command();
    int first, nargs, r, n, lim;
    first = stream_q.size();
    lim = effective_limit();
    r = $urandom_range(0, 99);
    if (r < 8) nargs = 0;
    else if (r < 85) nargs = $urandom_range(1, 4);
    else if (r < 95) nargs = $urandom_range(5, 10);
    else nargs = $urandom_range(ARG_LIMIT + 1, 200);
    add_byte(rcp_pkg::CH_STAR, 1'b1);
    add_decimal(nargs);
    add_byte(rcp_pkg::CH_CR, 1'b0);
    add_byte(8'($urandom_range(0, 255)), 1'b0);
    if (nargs > ARG_LIMIT) nargs = 0;
    for (int a = 0; a < nargs; a++) begin
      case ($urandom_range(0, 2))
        0: begin
          add_byte(rcp_pkg::CH_COLON, 1'b0);
          n = $urandom_range(0, 3);
          repeat (n) begin
            case ($urandom_range(0, 2))
              0: add_byte(rcp_pkg::CH_SPACE, 1'b0);
              1: add_byte(rcp_pkg::CH_TAB, 1'b0);
              default: add_byte(8'($urandom_range(10, 12)), 1'b0);
            endcase
          end
          r = $urandom_range(0, 2);
          if (r == 1) add_byte(rcp_pkg::CH_PLUS, 1'b0);
          else if (r == 2) add_byte(rcp_pkg::CH_MINUS, 1'b0);
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 6);
          repeat (n) add_byte(8'(rcp_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
          if ($urandom_range(0, 5) == 0) add_byte(8'($urandom_range(14, 255)), 1'b0);
          add_byte(rcp_pkg::CH_CR, 1'b0);
          add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        1: begin
          add_byte(rcp_pkg::CH_DOLLAR, 1'b0);
          n = $urandom_range(0, (lim > 12) ? 12 : ((lim > 1) ? lim - 1 : 0));
          if ($urandom_range(0, 19) == 0) n = lim;
          add_decimal(n);
          add_byte(rcp_pkg::CH_CR, 1'b0);
          add_byte(8'($urandom_range(0, 255)), 1'b0);
          // A length at the limit is refused, so its data is left out.
          if (n < lim) repeat (n) add_byte(8'($urandom_range(0, 255)), 1'b0);
          add_byte(8'($urandom_range(0, 255)), 1'b0);
          add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        default: begin
          add_byte(rcp_pkg::CH_PLUS, 1'b0);
          n = $urandom_range(0, 8);
          repeat (n) begin
            r = $urandom_range(0, 254);
            add_byte(8'((r >= rcp_pkg::CH_CR) ? r + 1 : r), 1'b0);
          end
          add_byte(rcp_pkg::CH_CR, 1'b0);
          add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(first, stream_q.size() - 1);
      stream_q[n].b = 8'($urandom_range(0, 255));
    end else if (r < 15 && stream_q.size() > first + 2) begin
      n = $urandom_range(first + 1, stream_q.size() - 1);
      stream_q = stream_q[0:n];
    end else if (r < 20) begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 23) begin
      // Pure noise, opening with a fresh message_start.
      add_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(0, 5))
        add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endfunction

  // Sends one byte after a random idle gap, which may be empty, and records it once it is accepted.
  task automatic send_byte(stream_byte_t s);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= s.b;
    in_ch.message_start <= s.st;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(s.b, s.st);
    bytes_sent++;
  endtask

  task automatic send_stream();
    while (stream_q.size() > 0) send_byte(stream_q.pop_front());
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Waits until every expected result has arrived and then lets the clock run on,
  // since the last bytes may still be in the pipeline without any result.
  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [12:0] value);
    drain();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.token_limit = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random phase: commands until the byte budget of the phase is spent.
  task automatic random_phase(int budget);
    int stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      gen_command();
      send_stream();
    end
  endtask

  // The receiver stalls in bursts whose lengths come from the gap picker.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    rcp_pkg::rcp_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.out_kind = out_ch.out_kind;
      got.data_byte = out_ch.data_byte;
      got.number_value = out_ch.number_value;
      got.arg_length = out_ch.arg_length;
      got.arg_index = out_ch.arg_index;
      got.last_arg = out_ch.last_arg;
      sb.check_result(got);
    end
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [12:0] limits[$];
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.message_start = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    quiet = 1'b0;
    bytes_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset limit of 256: an empty command, a command
    // holding every argument type with the most negative and a saturating
    // number, blanks and stop bytes in a number, an empty number, the
    // largest argument count, the bulk lengths at and just below the limit,
    // and the error cases, several followed by a byte that must repeat the error.
    add_text("*0\015\012", 1'b1);
    add_byte(8'hFF, 1'b0);
    add_text("*4\015\012:-9223372036854775809\015\012$3\015\012a\015c\377\001", 1'b1);
    add_text("+hi\015\012:  +12x3\015\012", 1'b0);
    add_text("*2\015\012:99999999999999999999\015\012:\015\012", 1'b1);
    add_text("*64\015\012:1\015\012", 1'b1);
    add_text("*65\015\012", 1'b1);
    add_byte(8'h00, 1'b0);
    add_text("*1\015\012?x", 1'b1);
    add_text("*1\015\012\015", 1'b1);
    add_text("x*", 1'b1);
    add_text("\015", 1'b1);
    add_text("*1a", 1'b1);
    add_text("*1\015\012$256\015\012", 1'b1);
    add_text("*1\015\012$255\015\012", 1'b1);
    send_stream();

    // Random phases over several limits, the extremes and values out of
    // range among them; the quiet phases run without random gaps or stalls.
    random_phase(60);
    limits = '{13'd4096, 13'd2, 13'd8191, 13'd0, 13'd1, 13'd3, 13'd40, 13'd256};
    foreach (limits[i]) begin
      write_limit(limits[i]);
      quiet = (i % 3 == 2);
      random_phase((limits[i] < 4) ? 5 : 20);
    end
    quiet = 1'b0;
    write_limit(13'($urandom_range(2, 300)));
    random_phase(20);

    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
rtl/rcp_pkg.sv
rtl/rcp_if.sv
rtl/rcp_queue.sv
rtl/rcp_engine.sv
rtl/resp_command_parser_unit.sv
sim/resp_command_parser_unit_tb.sv
